[hw/rtl/ets_pkg.sv]
`timescale 1ns / 1ps

package ets_pkg;

	// Field widths
	localparam int unsigned RAW_W    = 32;
	localparam int unsigned WRAP_W   = 32;
	localparam int unsigned TOTAL_W  = RAW_W + WRAP_W;
	localparam int unsigned SEC_W    = 45;
	localparam int unsigned PART_W   = 10;
	localparam int unsigned MICROS_W = 64;
	localparam int unsigned TPU_W    = 12;

	// Shared divider: 64-bit dividend, divisor up to one million
	localparam int unsigned DVD_W  = 64;
	localparam int unsigned DSR_W  = 20;
	localparam int unsigned STEP_W = $clog2(DVD_W);

	// APB port
	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;

	// Register index
	localparam logic REG_TICKS_PER_US = 1'b0;

	// Time constants
	localparam logic [DSR_W-1:0] US_PER_S  = DSR_W'(1000000);
	localparam logic [DSR_W-1:0] US_PER_MS = DSR_W'(1000);
	localparam logic [TPU_W-1:0] TPU_RESET = TPU_W'(1);

	// Sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_RATE,
		S_SEC,
		S_MS,
		S_LOAD
	} seq_state_t;

	// Request into the shared divider
	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DSR_W-1:0] divisor;
	} div_req_t;

	// Status out of the shared divider
	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DVD_W-1:0] quotient;
		logic [DSR_W-1:0] remainder;
	} div_stat_t;

endpackage

[hw/rtl/ets_if.sv]
`timescale 1ns / 1ps

// Counter sample channel
interface ets_in_if;
	logic                      valid;
	logic                      ready;
	logic [ets_pkg::RAW_W-1:0] raw_count;

	modport source (output valid, output raw_count, input ready);
	modport sink (input valid, input raw_count, output ready);
endinterface

// Split timestamp channel
interface ets_out_if;
	logic                         valid;
	logic                         ready;
	logic [ets_pkg::SEC_W-1:0]    seconds;
	logic [ets_pkg::PART_W-1:0]   millis_part;
	logic [ets_pkg::PART_W-1:0]   micros_part;
	logic [ets_pkg::MICROS_W-1:0] total_micros;

	modport source (output valid, output seconds, output millis_part, output micros_part,
		output total_micros, input ready);
	modport sink (input valid, input seconds, input millis_part, input micros_part,
		input total_micros, output ready);
endinterface

[hw/rtl/extended_timestamp_time_split_unit.sv]
`timescale 1ns / 1ps

// Extends samples of a free-running 32-bit tick counter to 64 bits and
// splits the tick total into seconds, milliseconds and microseconds.
// sample: one beat per counter sample. A sample below the previous one
//   counts one wrap; the wrap count forms the upper 32 bits of the total.
// timestamp: one beat per sample with seconds, millis_part, micros_part
//   and total_micros.
// APB: register 0 (byte address 0) holds ticks_per_us, 12 bits, reset 1;
//   a value of zero is used as one. Write it only while idle.
// Sequencing: one shared radix-2 divider runs three passes of 64 steps
//   (ticks / rate, micros / 1000000, remainder / 1000), and the result is
//   then loaded into the output register. sample.ready is high only while
//   the sequencer is idle, so one sample is in work at a time.
// The result sits in an output register; a new sample is taken while it
//   waits, but that sample's result is held until the slot frees up.
// Reset clears the previous sample, the wrap count and the handshakes,
//   and sets ticks_per_us to 1.
module extended_timestamp_time_split_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	ets_in_if.sink                      sample,
	ets_out_if.source                   timestamp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ets_pkg::PADDR_W-1:0] paddr,
	input  logic [ets_pkg::PDATA_W-1:0] pwdata,
	output logic [ets_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);
	import ets_pkg::*;

	seq_state_t          state_q, state_nxt;
	div_req_t            req;
	div_stat_t           stat;
	logic [DSR_W-1:0]    rate;

	logic [RAW_W-1:0]    prev_q;
	logic [WRAP_W-1:0]   wrap_q;
	logic [WRAP_W-1:0]   wrap_nxt;
	logic                accept;
	logic                slot_free;

	logic [MICROS_W-1:0] micros_q;
	logic [SEC_W-1:0]    sec_q;
	logic [PART_W-1:0]   ms_q;
	logic [PART_W-1:0]   us_q;

	logic                out_valid_q;
	logic [SEC_W-1:0]    out_sec_q;
	logic [PART_W-1:0]   out_ms_q;
	logic [PART_W-1:0]   out_us_q;
	logic [MICROS_W-1:0] out_micros_q;

	ets_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.rate    (rate)
	);

	ets_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.stat   (stat)
	);

	assign sample.ready = (state_q == S_IDLE);
	assign accept       = sample.valid && sample.ready;
	assign slot_free    = !out_valid_q || timestamp.ready;
	assign wrap_nxt     = (sample.raw_count < prev_q) ? wrap_q + WRAP_W'(1) : wrap_q;

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: if (accept) state_nxt = S_RATE;
			S_RATE: if (stat.done) state_nxt = S_SEC;
			S_SEC:  if (stat.done) state_nxt = S_MS;
			S_MS:   if (stat.done) state_nxt = S_LOAD;
			S_LOAD: if (slot_free) state_nxt = S_IDLE;
			default: state_nxt = S_IDLE;
		endcase
	end

	// Divider requests per pass
	always_comb begin
		req.start    = 1'b0;
		req.dividend = {wrap_nxt, sample.raw_count};
		req.divisor  = rate;
		case (state_q)
			S_IDLE: begin
				req.start = accept;
			end
			S_RATE: begin
				req.start    = stat.done;
				req.dividend = stat.quotient;
				req.divisor  = US_PER_S;
			end
			S_SEC: begin
				req.start    = stat.done;
				req.dividend = {{(DVD_W-DSR_W){1'b0}}, stat.remainder};
				req.divisor  = US_PER_MS;
			end
			default: begin
				req.start = 1'b0;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			prev_q      <= '0;
			wrap_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				prev_q <= sample.raw_count;
				wrap_q <= wrap_nxt;
			end
			if (state_q == S_LOAD && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (timestamp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Pass results and output register
	always_ff @(posedge clk) begin
		if (state_q == S_RATE && stat.done) micros_q <= stat.quotient;
		if (state_q == S_SEC && stat.done) sec_q <= stat.quotient[SEC_W-1:0];
		if (state_q == S_MS && stat.done) begin
			ms_q <= stat.quotient[PART_W-1:0];
			us_q <= stat.remainder[PART_W-1:0];
		end
		if (state_q == S_LOAD && slot_free) begin
			out_sec_q    <= sec_q;
			out_ms_q     <= ms_q;
			out_us_q     <= us_q;
			out_micros_q <= micros_q;
		end
	end

	assign timestamp.valid        = out_valid_q;
	assign timestamp.seconds      = out_sec_q;
	assign timestamp.millis_part  = out_ms_q;
	assign timestamp.micros_part  = out_us_q;
	assign timestamp.total_micros = out_micros_q;

	// Checks
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_RATE) && stat.busy)
		else $error("accepted sample did not start a division");
	a_done_in_pass: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |-> (state_q == S_RATE || state_q == S_SEC || state_q == S_MS))
		else $error("divider finished outside a pass");
	a_load_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOAD && slot_free) |=> out_valid_q && (state_q == S_IDLE))
		else $error("result not loaded into output register");
	a_parts_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOAD) |-> (ms_q < PART_W'(1000) && us_q < PART_W'(1000)))
		else $error("millisecond or microsecond part out of range");

endmodule

[hw/rtl/ets_divider.sv]
`timescale 1ns / 1ps

module ets_divider (
	input  logic               clk,
	input  logic               arst_n,
	input  ets_pkg::div_req_t  req,
	output ets_pkg::div_stat_t stat
);
	import ets_pkg::*;

	logic [DVD_W-1:0]  quo_q;
	logic [DSR_W-1:0]  rem_q;
	logic [DSR_W-1:0]  dsr_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [DSR_W:0]    trial;
	logic [DSR_W:0]    diff;
	logic              fits;

	// One restoring step: shift in next dividend bit, subtract if it fits
	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = (trial >= {1'b0, dsr_q});

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + STEP_W'(1);
				if (cnt_q == STEP_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DVD_W-2:0], fits};
			rem_q <= fits ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
		end
	end

	assign stat.busy      = busy_q;
	assign stat.done      = done_q;
	assign stat.quotient  = quo_q;
	assign stat.remainder = rem_q;

	// Checks
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("divider started while busy");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divider done without a run");
	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (rem_q < dsr_q))
		else $error("divider remainder not below divisor");

endmodule

[hw/rtl/ets_apb_regs.sv]
`timescale 1ns / 1ps

module ets_apb_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ets_pkg::PADDR_W-1:0]  paddr,
	input  logic [ets_pkg::PDATA_W-1:0]  pwdata,
	output logic [ets_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	output logic [ets_pkg::DSR_W-1:0]    rate
);
	import ets_pkg::*;

	logic [TPU_W-1:0] tpu_q;
	logic             hit;

	assign pready = 1'b1;
	assign hit    = (paddr[2] == REG_TICKS_PER_US);

	// Register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpu_q <= TPU_RESET;
		end else if (psel && penable && pwrite && hit) begin
			tpu_q <= pwdata[TPU_W-1:0];
		end
	end

	// Readback
	assign prdata = hit ? {{(PDATA_W-TPU_W){1'b0}}, tpu_q} : '0;

	// Zero rate counts as one tick per microsecond
	assign rate = (tpu_q == '0) ? DSR_W'(1) : {{(DSR_W-TPU_W){1'b0}}, tpu_q};

endmodule
